[rtl/iswc_pkg.sv]
// ----------------------------------------------------------------------------
// iswc_pkg: shared definitions for the insertion sorter
// Sizes, count limits and the command/status bundles that join the
// controller to the datapath.
// ----------------------------------------------------------------------------
package iswc_pkg;

	// buffer geometry
	localparam int DEPTH   = 32;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int FILL_W  = $clog2(DEPTH + 1);
	localparam int VALUE_W = 32;

	// count fields and their saturation limits
	localparam int MOVE_W = 10;
	localparam int CMP_W  = 9;
	localparam logic [MOVE_W-1:0] MOVE_MAX = '1;
	localparam logic [CMP_W-1:0]  CMP_MAX  = '1;

	// controller to datapath
	typedef struct packed {
		logic load;      // store the input beat, or flag it dropped
		logic start;     // first pass index, clear counts and output index
		logic rd_t;      // read the element that this pass inserts
		logic cap_t;     // latch that element and open the pass
		logic rd_prev;   // read the neighbor below the hole
		logic cmp_step;  // compare, then shift the neighbor up or place the element
		logic place0;    // place the element at the bottom
		logic next_pass; // advance the pass index
		logic rd_out;    // read the next sorted element
		logic ld_out;    // load the output register
		logic out_next;  // advance the output index
		logic clear;     // empty the buffer for the next set
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pos_zero;  // hole is at the bottom
		logic ooo;       // neighbor must move past the element
		logic pass_done; // the current pass was the last one
		logic few;       // one element or none: nothing to sort
		logic out_last;  // output index is at the last element
		logic out_taken; // output beat accepted this cycle
	} status_t;

endpackage

[rtl/iswc_datapath.sv]
// ----------------------------------------------------------------------------
// iswc_datapath: element buffer, pass registers, counters and output register
// One-write, one-read buffer with a registered read port; the controller
// steps it through loading, insertion passes and readout.
// ----------------------------------------------------------------------------
module iswc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iswc_pkg::cmd_t                 cmd,
	output iswc_pkg::status_t              status,
	input  logic                           cfg_we,
	input  logic                           cfg_desc,
	input  logic signed [iswc_pkg::VALUE_W-1:0] value,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic signed [iswc_pkg::VALUE_W-1:0] sorted_value,
	output logic                           final_res,
	output logic [iswc_pkg::MOVE_W-1:0]    move_count,
	output logic [iswc_pkg::CMP_W-1:0]     compare_count,
	output logic                           dropped
);
	import iswc_pkg::*;

	logic signed [VALUE_W-1:0] mem [DEPTH];
	logic signed [VALUE_W-1:0] rd_q;
	logic signed [VALUE_W-1:0] t_q;
	logic [FILL_W-1:0]         fill_q;
	logic                      ovf_q;
	logic                      desc_q;
	logic [ADDR_W-1:0]         i_q;
	logic [ADDR_W-1:0]         pos_q;
	logic [ADDR_W-1:0]         k_q;
	logic [MOVE_W-1:0]         move_q;
	logic [CMP_W-1:0]          cmp_q;
	logic                      out_valid_q;

	logic [ADDR_W-1:0]         raddr;
	logic [ADDR_W-1:0]         waddr;
	logic signed [VALUE_W-1:0] wdata;
	logic                      we;
	logic                      room;
	logic                      ooo;
	logic                      move_inc;
	logic                      k_last;

	// decide order between the stored neighbor and the element in hand
	assign ooo  = desc_q ? (rd_q < t_q) : (rd_q > t_q);
	assign room = (fill_q < FILL_W'(DEPTH));
	assign k_last = ((FILL_W'(k_q) + FILL_W'(1)) == fill_q);

	// select read address for the step in progress
	always_comb begin
		priority if (cmd.rd_t) begin
			raddr = i_q;
		end else if (cmd.rd_prev) begin
			raddr = pos_q - ADDR_W'(1);
		end else begin
			raddr = k_q;
		end
	end

	// select write address and data
	always_comb begin
		we    = (cmd.load && room) || cmd.cmp_step || cmd.place0;
		waddr = cmd.load ? fill_q[ADDR_W-1:0] : pos_q;
		priority if (cmd.load) begin
			wdata = value;
		end else if (cmd.cmp_step && ooo) begin
			wdata = rd_q;
		end else begin
			wdata = t_q;
		end
	end

	// buffer storage, registered read on a read command
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_t || cmd.rd_prev || cmd.rd_out) begin
			rd_q <= mem[raddr];
		end
	end

	assign move_inc = cmd.cap_t || cmd.cmp_step || cmd.place0;

	// fill level, drop flag and mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
			desc_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				desc_q <= cfg_desc;
			end
			if (cmd.clear) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.load) begin
				if (room) begin
					fill_q <= fill_q + FILL_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// pass index, hole position, element in hand, output index
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			i_q <= ADDR_W'(1);
			k_q <= '0;
		end else begin
			if (cmd.next_pass) begin
				i_q <= i_q + ADDR_W'(1);
			end
			if (cmd.out_next) begin
				k_q <= k_q + ADDR_W'(1);
			end
		end
		if (cmd.cap_t) begin
			t_q   <= rd_q;
			pos_q <= i_q;
		end else if (cmd.cmp_step && ooo) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
	end

	// saturating move and comparison counters
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			move_q <= '0;
			cmp_q  <= '0;
		end else begin
			if (move_inc && (move_q != MOVE_MAX)) begin
				move_q <= move_q + MOVE_W'(1);
			end
			if (cmd.cmp_step && (cmp_q != CMP_MAX)) begin
				cmp_q <= cmp_q + CMP_W'(1);
			end
		end
	end

	// output valid: set on load, drop on accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.ld_out) begin
			sorted_value  <= rd_q;
			final_res     <= k_last;
			move_count    <= k_last ? move_q : '0;
			compare_count <= k_last ? cmp_q : '0;
			dropped       <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

	// status back to the controller
	assign status.pos_zero  = (pos_q == '0);
	assign status.ooo       = ooo;
	assign status.pass_done = ((FILL_W'(i_q) + FILL_W'(1)) == fill_q);
	assign status.few       = (fill_q <= FILL_W'(1));
	assign status.out_last  = k_last;
	assign status.out_taken = out_valid_q && out_ready;

endmodule

[rtl/iswc_ctrl.sv]
// ----------------------------------------------------------------------------
// iswc_ctrl: sequencing state machine for the insertion sorter
// Walks load, insertion passes and readout, issuing one command set per cycle.
// ----------------------------------------------------------------------------
module iswc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last,
	output logic               in_ready,
	input  iswc_pkg::status_t  status,
	output iswc_pkg::cmd_t     cmd
);
	import iswc_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SORT_CHK = 4'd1;
	localparam logic [3:0] ST_RD_T     = 4'd2;
	localparam logic [3:0] ST_CAP_T    = 4'd3;
	localparam logic [3:0] ST_CMP_RD   = 4'd4;
	localparam logic [3:0] ST_CMP      = 4'd5;
	localparam logic [3:0] ST_NEXT     = 4'd6;
	localparam logic [3:0] ST_OUT_RD   = 4'd7;
	localparam logic [3:0] ST_OUT_LD   = 4'd8;
	localparam logic [3:0] ST_OUT_WAIT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (last) begin
						state_d = ST_SORT_CHK;
					end
				end
			end
			ST_SORT_CHK: begin
				cmd.start = 1'b1;
				state_d   = status.few ? ST_OUT_RD : ST_RD_T;
			end
			ST_RD_T: begin
				cmd.rd_t = 1'b1;
				state_d  = ST_CAP_T;
			end
			ST_CAP_T: begin
				cmd.cap_t = 1'b1;
				state_d   = ST_CMP_RD;
			end
			ST_CMP_RD: begin
				if (status.pos_zero) begin
					cmd.place0 = 1'b1;
					state_d    = ST_NEXT;
				end else begin
					cmd.rd_prev = 1'b1;
					state_d     = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp_step = 1'b1;
				state_d      = status.ooo ? ST_CMP_RD : ST_NEXT;
			end
			ST_NEXT: begin
				if (status.pass_done) begin
					state_d = ST_OUT_RD;
				end else begin
					cmd.next_pass = 1'b1;
					state_d       = ST_RD_T;
				end
			end
			ST_OUT_RD: begin
				cmd.rd_out = 1'b1;
				state_d    = ST_OUT_LD;
			end
			ST_OUT_LD: begin
				cmd.ld_out = 1'b1;
				state_d    = ST_OUT_WAIT;
			end
			ST_OUT_WAIT: begin
				if (status.out_taken) begin
					if (status.out_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = ST_OUT_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/insertion_sorter_with_counts.sv]
// ----------------------------------------------------------------------------
// insertion_sorter_with_counts: buffered insertion sort with move/compare counts
// Collects a set of signed values, sorts it ascending or descending and
// streams the sorted set out with counts on the final beat.
//
//   channel | signals                                    | beat
//   --------+--------------------------------------------+----------------------
//   in      | in_valid, in_ready, value, last            | one element
//   out     | out_valid, out_ready, sorted_value,        | one sorted element
//           | final_res, move_count, compare_count,      |
//           | dropped                                    |
//   cfg     | cfg_valid, cfg_ready, descending           | sort direction
//
// Loading stores each element as it arrives; the sort opens with a setup step.
// Each insertion pass reads and latches its element, then reads and compares
// each neighbor in turn, placing the element at the bottom when it sinks there,
// all through the single buffer read port; readout reads and loads each element.
// Input is taken only between sets; out_ready low holds the current result.
// Reset clears the fill level, drop flag, direction and state machine;
// the buffer itself needs no clearing.
// ----------------------------------------------------------------------------
module insertion_sorter_with_counts (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [iswc_pkg::VALUE_W-1:0]  value,
	input  logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [iswc_pkg::VALUE_W-1:0]  sorted_value,
	output logic                                 final_res,
	output logic [iswc_pkg::MOVE_W-1:0]          move_count,
	output logic [iswc_pkg::CMP_W-1:0]           compare_count,
	output logic                                 dropped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 descending
);
	import iswc_pkg::*;

	cmd_t    cmd;
	status_t status;

	// direction register always takes a write
	assign cfg_ready = 1'b1;

	iswc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.last     (last),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	iswc_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_desc      (descending),
		.value         (value),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.sorted_value  (sorted_value),
		.final_res     (final_res),
		.move_count    (move_count),
		.compare_count (compare_count),
		.dropped       (dropped)
	);

	// never load while a result is pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	// counts are zero except on the final beat
	a_counts_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !final_res) |-> (move_count == '0 && compare_count == '0))
		else $error("counts shown on a non-final beat");

	// final beat returns the block to loading
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && final_res) |=> in_ready)
		else $error("block not ready after final beat");

	// a load is never followed directly by a result
	a_load_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result appeared right after a load");

endmodule
